@@ rtl/ffha_pkg.sv @@
// Shared types and constants of the first-fit heap allocator.
package ffha_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned CUR_W = 33;
  localparam int unsigned HDR_BYTES = 12;
  localparam logic [WORD_W-1:0] HDR_MAGIC = 32'hDEADBEEF;
  localparam logic [WORD_W-1:0] FLAG_FREE = 32'd1;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_NOFIT   = 2'd1,
    STAT_CORRUPT = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    BASE_CUR  = 2'd0,
    BASE_NH   = 2'd1,
    BASE_ZERO = 2'd2
  } base_t;

  typedef enum logic [1:0] {
    WOFF_SIZE  = 2'd0,
    WOFF_FLAG  = 2'd1,
    WOFF_MAGIC = 2'd2
  } woff_t;

  typedef enum logic [2:0] {
    WSRC_REQ   = 3'd0,
    WSRC_LEFT  = 3'd1,
    WSRC_FREE  = 3'd2,
    WSRC_USED  = 3'd3,
    WSRC_MAGIC = 3'd4,
    WSRC_INIT  = 3'd5
  } wsrc_t;

  typedef struct packed {
    logic    mem_en;
    logic    mem_we;
    base_t   base;
    woff_t   woff;
    wsrc_t   wsrc;
    logic    start_item;
    logic    load_bsize;
    logic    load_nh;
    logic    adv_cur;
    logic    shrink;
    logic    res_load;
    status_t res_status;
  } cmd_t;

  typedef struct packed {
    logic oversize;
    logic at_end;
    logic past_end;
    logic magic_ok;
    logic fit;
    logic split;
  } sts_t;

endpackage

@@ rtl/ffha_ram.sv @@
// Generic single-port RAM with registered read data.
module ffha_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end
      rdata <= mem[addr];
    end
  end

endmodule

@@ rtl/ffha_datapath.sv @@
// Datapath: heap byte lanes, walk pointer, header fields and result registers.
module ffha_datapath import ffha_pkg::*; #(
  parameter int unsigned HEAP_BYTES = 65536,
  parameter int unsigned MIN_LEFTOVER = 16
) (
  input  logic        clk,
  input  logic [16:0] in_req_size,
  input  cmd_t        cmd,
  output sts_t        sts,
  output logic [1:0]  out_status,
  output logic [15:0] out_payload_offset,
  output logic [15:0] out_granted_size
);

  localparam int unsigned AW = $clog2(HEAP_BYTES);
  localparam int unsigned LANE_DEPTH = (HEAP_BYTES + 3) / 4;
  localparam int unsigned RW = $clog2(LANE_DEPTH);
  localparam logic [CUR_W-1:0] HEAP_LIMIT = CUR_W'(HEAP_BYTES);
  localparam logic [WORD_W-1:0] SPLIT_MIN = WORD_W'(HDR_BYTES + MIN_LEFTOVER);
  localparam logic [WORD_W-1:0] INIT_SIZE = WORD_W'(HEAP_BYTES - HDR_BYTES);

  logic [16:0]       req_r;
  logic [CUR_W-1:0]  cur_r;
  logic [WORD_W-1:0] bsize_r;
  logic [AW-1:0]     nh_r;
  logic [1:0]        boff_r;
  logic [1:0]        status_r;
  logic [15:0]       offset_r;
  logic [15:0]       gsize_r;

  logic [WORD_W-1:0] req_ext;
  logic [WORD_W-1:0] left;
  logic [WORD_W-1:0] rd_word;
  logic [WORD_W-1:0] wword;
  logic [AW-1:0]     base;
  logic [AW-1:0]     addr;
  logic [7:0]        lane_rd [4];

  assign req_ext = WORD_W'(req_r);
  assign left = bsize_r - req_ext;

  always_comb begin
    case (cmd.base)
      BASE_CUR:  base = AW'(cur_r);
      BASE_NH:   base = nh_r;
      BASE_ZERO: base = '0;
      default:   base = '0;
    endcase
  end

  assign addr = base + AW'({cmd.woff, 2'b00});

  always_comb begin
    case (cmd.wsrc)
      WSRC_REQ:   wword = req_ext;
      WSRC_LEFT:  wword = left - WORD_W'(HDR_BYTES);
      WSRC_FREE:  wword = FLAG_FREE;
      WSRC_USED:  wword = '0;
      WSRC_MAGIC: wword = HDR_MAGIC;
      WSRC_INIT:  wword = INIT_SIZE;
      default:    wword = '0;
    endcase
  end

  for (genvar L = 0; L < 4; L++) begin : g_lane
    logic [1:0]    k;
    logic [AW-1:0] baddr;
    logic [RW-1:0] row;
    logic [7:0]    wbyte;
    assign k = 2'(L) - addr[1:0];
    assign baddr = addr + AW'(k);
    assign row = baddr[RW+1:2];
    assign wbyte = 8'(wword >> {k, 3'b000});
    ffha_ram #(
      .WIDTH(8),
      .DEPTH(LANE_DEPTH)
    ) u_ram (
      .clk   (clk),
      .en    (cmd.mem_en),
      .we    (cmd.mem_we),
      .addr  (row),
      .wdata (wbyte),
      .rdata (lane_rd[L])
    );
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      rd_word[8*k +: 8] = lane_rd[2'(boff_r + 2'(k))];
    end
  end

  assign sts.oversize = CUR_W'(req_r) > HEAP_LIMIT;
  assign sts.at_end = cur_r >= HEAP_LIMIT;
  assign sts.past_end = (cur_r + CUR_W'(HDR_BYTES)) > HEAP_LIMIT;
  assign sts.magic_ok = rd_word == HDR_MAGIC;
  assign sts.fit = (bsize_r >= req_ext) && (rd_word == FLAG_FREE);
  assign sts.split = left > SPLIT_MIN;

  always_ff @(posedge clk) begin
    if (cmd.start_item) begin
      req_r <= in_req_size;
      cur_r <= '0;
    end else if (cmd.adv_cur) begin
      cur_r <= cur_r + CUR_W'(HDR_BYTES) + CUR_W'(bsize_r);
    end
    if (cmd.load_bsize) begin
      bsize_r <= rd_word;
    end else if (cmd.shrink) begin
      bsize_r <= req_ext;
    end
    if (cmd.mem_en) begin
      boff_r <= addr[1:0];
    end
    if (cmd.load_nh) begin
      nh_r <= AW'(cur_r) + AW'(HDR_BYTES) + AW'(req_r);
    end
    if (cmd.res_load) begin
      status_r <= cmd.res_status;
      if (cmd.res_status == STAT_OK) begin
        offset_r <= 16'(cur_r + CUR_W'(HDR_BYTES));
        gsize_r <= bsize_r[15:0];
      end else begin
        offset_r <= '0;
        gsize_r <= '0;
      end
    end
  end

  assign out_status = status_r;
  assign out_payload_offset = offset_r;
  assign out_granted_size = gsize_r;

endmodule

@@ rtl/ffha_ctrl.sv @@
// Controller state machine: heap setup, header walk, split and grant sequencing.
module ffha_ctrl import ffha_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  sts_t sts,
  output cmd_t cmd,
  output logic busy,
  output logic out_valid
);

  typedef enum logic [13:0] {
    S_INIT0  = 14'b00000000000001,
    S_INIT1  = 14'b00000000000010,
    S_INIT2  = 14'b00000000000100,
    S_IDLE   = 14'b00000000001000,
    S_WALK   = 14'b00000000010000,
    S_RMAG   = 14'b00000000100000,
    S_RSIZE  = 14'b00000001000000,
    S_RFLAG  = 14'b00000010000000,
    S_SPLIT0 = 14'b00000100000000,
    S_SPLIT1 = 14'b00001000000000,
    S_SPLIT2 = 14'b00010000000000,
    S_SPLIT3 = 14'b00100000000000,
    S_MARK   = 14'b01000000000000,
    S_DONE   = 14'b10000000000000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT0;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_INIT0: begin
        cmd.mem_en = 1'b1;
        cmd.mem_we = 1'b1;
        cmd.base = BASE_ZERO;
        cmd.woff = WOFF_SIZE;
        cmd.wsrc = WSRC_INIT;
        state_nxt = S_INIT1;
      end
      S_INIT1: begin
        cmd.mem_en = 1'b1;
        cmd.mem_we = 1'b1;
        cmd.base = BASE_ZERO;
        cmd.woff = WOFF_FLAG;
        cmd.wsrc = WSRC_FREE;
        state_nxt = S_INIT2;
      end
      S_INIT2: begin
        cmd.mem_en = 1'b1;
        cmd.mem_we = 1'b1;
        cmd.base = BASE_ZERO;
        cmd.woff = WOFF_MAGIC;
        cmd.wsrc = WSRC_MAGIC;
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.start_item = 1'b1;
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (sts.oversize || sts.at_end) begin
          cmd.res_load = 1'b1;
          cmd.res_status = STAT_NOFIT;
          state_nxt = S_DONE;
        end else if (sts.past_end) begin
          cmd.res_load = 1'b1;
          cmd.res_status = STAT_CORRUPT;
          state_nxt = S_DONE;
        end else begin
          cmd.mem_en = 1'b1;
          cmd.base = BASE_CUR;
          cmd.woff = WOFF_MAGIC;
          state_nxt = S_RMAG;
        end
      end
      S_RMAG: begin
        if (!sts.magic_ok) begin
          cmd.res_load = 1'b1;
          cmd.res_status = STAT_CORRUPT;
          state_nxt = S_DONE;
        end else begin
          cmd.mem_en = 1'b1;
          cmd.base = BASE_CUR;
          cmd.woff = WOFF_SIZE;
          state_nxt = S_RSIZE;
        end
      end
      S_RSIZE: begin
        cmd.load_bsize = 1'b1;
        cmd.mem_en = 1'b1;
        cmd.base = BASE_CUR;
        cmd.woff = WOFF_FLAG;
        state_nxt = S_RFLAG;
      end
      S_RFLAG: begin
        if (sts.fit) begin
          cmd.load_nh = 1'b1;
          state_nxt = sts.split ? S_SPLIT0 : S_MARK;
        end else begin
          cmd.adv_cur = 1'b1;
          state_nxt = S_WALK;
        end
      end
      S_SPLIT0: begin
        cmd.mem_en = 1'b1;
        cmd.mem_we = 1'b1;
        cmd.base = BASE_CUR;
        cmd.woff = WOFF_SIZE;
        cmd.wsrc = WSRC_REQ;
        state_nxt = S_SPLIT1;
      end
      S_SPLIT1: begin
        cmd.mem_en = 1'b1;
        cmd.mem_we = 1'b1;
        cmd.base = BASE_NH;
        cmd.woff = WOFF_SIZE;
        cmd.wsrc = WSRC_LEFT;
        state_nxt = S_SPLIT2;
      end
      S_SPLIT2: begin
        cmd.mem_en = 1'b1;
        cmd.mem_we = 1'b1;
        cmd.base = BASE_NH;
        cmd.woff = WOFF_FLAG;
        cmd.wsrc = WSRC_FREE;
        state_nxt = S_SPLIT3;
      end
      S_SPLIT3: begin
        cmd.mem_en = 1'b1;
        cmd.mem_we = 1'b1;
        cmd.base = BASE_NH;
        cmd.woff = WOFF_MAGIC;
        cmd.wsrc = WSRC_MAGIC;
        cmd.shrink = 1'b1;
        state_nxt = S_MARK;
      end
      S_MARK: begin
        cmd.mem_en = 1'b1;
        cmd.mem_we = 1'b1;
        cmd.base = BASE_CUR;
        cmd.woff = WOFF_FLAG;
        cmd.wsrc = WSRC_USED;
        cmd.res_load = 1'b1;
        cmd.res_status = STAT_OK;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = state_r != S_IDLE;
  assign out_valid = state_r == S_DONE;

endmodule

@@ rtl/first_fit_heap_allocator_unit.sv @@
// Top level of the first-fit heap allocator: controller and datapath.
//
//   Channel   Ports                                        Handshake
//   request   in_req_size                                  start & !busy
//   result    out_status, out_payload_offset,              out_valid, one cycle
//             out_granted_size
//
// The walk reads the magic, size and flag words of each header in turn from the
// single-port byte-lane heap RAM (S_WALK, S_RMAG, S_RSIZE) and tests the fit in
// S_RFLAG. A fit with a split writes the shrunk size and the new free header
// (S_SPLIT0 to S_SPLIT3) before S_MARK; a bad magic word ends the walk in S_RMAG.
// After reset the block stays busy while it writes the initial free header at
// offset zero; the rest of the heap is never read before it is written.
// The receiver cannot stall: each result beat is shown for exactly one cycle.
module first_fit_heap_allocator_unit import ffha_pkg::*; #(
  parameter int unsigned HEAP_BYTES = 65536,
  parameter int unsigned MIN_LEFTOVER = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [16:0] in_req_size,
  output logic        busy,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [15:0] out_payload_offset,
  output logic [15:0] out_granted_size
);

  cmd_t cmd;
  sts_t sts;

  ffha_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  ffha_datapath #(
    .HEAP_BYTES   (HEAP_BYTES),
    .MIN_LEFTOVER (MIN_LEFTOVER)
  ) u_dp (
    .clk                (clk),
    .in_req_size        (in_req_size),
    .cmd                (cmd),
    .sts                (sts),
    .out_status         (out_status),
    .out_payload_offset (out_payload_offset),
    .out_granted_size   (out_granted_size)
  );

endmodule

@@ rtl/ffha_checker.sv @@
// Port-level checker of the first-fit heap allocator and its bind statement.
module ffha_checker import ffha_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [1:0]  out_status,
  input logic [15:0] out_payload_offset,
  input logic [15:0] out_granted_size
);

  a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("Result beat lasted more than one cycle.");

  a_busy_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("Result beat shown while the block was idle.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("Block not busy after accepting a request.");

  a_zero_unless_granted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != STAT_OK)) |->
      ((out_payload_offset == 16'd0) && (out_granted_size == 16'd0)))
    else $error("Refused request carries a nonzero offset or size.");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_status == STAT_OK) || (out_status == STAT_NOFIT) ||
                   (out_status == STAT_CORRUPT)))
    else $error("Result carries an undefined status code.");

endmodule

bind first_fit_heap_allocator_unit ffha_checker u_ffha_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .start              (start),
  .busy               (busy),
  .out_valid          (out_valid),
  .out_status         (out_status),
  .out_payload_offset (out_payload_offset),
  .out_granted_size   (out_granted_size)
);

@@ tb/tb_top.sv @@
// Self-checking testbench for the first-fit heap allocator, with a heap mirror as predictor.
module tb_top;
  import ffha_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HEAP_BYTES = 65536;
  localparam int unsigned MIN_LEFTOVER = 16;
  localparam int unsigned STALL_LIMIT = 50000;
  localparam int unsigned RANDOM_BEATS = 1430;

  typedef struct packed {
    status_t     status;
    logic [15:0] payload_offset;
    logic [15:0] granted_size;
  } grant_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic [16:0] in_req_size = '0;
  logic        busy;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [15:0] out_payload_offset;
  logic [15:0] out_granted_size;

  logic [7:0]  heap_mirror [0:HEAP_BYTES-1];
  grant_t      pending_grants [$];
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles = 0;

  first_fit_heap_allocator_unit #(
    .HEAP_BYTES(HEAP_BYTES),
    .MIN_LEFTOVER(MIN_LEFTOVER)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .in_req_size(in_req_size),
    .busy(busy),
    .out_valid(out_valid),
    .out_status(out_status),
    .out_payload_offset(out_payload_offset),
    .out_granted_size(out_granted_size)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] heap_rd32(input longint unsigned at);
    logic [31:0] v;
    v = '0;
    for (int k = 0; k < 4; k++) begin
      if (at + k < HEAP_BYTES) v[8*k +: 8] = heap_mirror[at + k];
    end
    return v;
  endfunction

  function automatic void heap_wr32(input longint unsigned at, input logic [31:0] v);
    for (int k = 0; k < 4; k++) begin
      if (at + k < HEAP_BYTES) heap_mirror[at + k] = v[8*k +: 8];
    end
  endfunction

  // Walks the mirrored headers first-fit and applies the grant to the mirror.
  function automatic grant_t predict_grant(input logic [16:0] req);
    grant_t          g;
    longint unsigned cur;
    logic [31:0]     bsize;
    logic [31:0]     flag;
    logic [31:0]     left;
    g.status = STAT_NOFIT;
    g.payload_offset = '0;
    g.granted_size = '0;
    if (req > HEAP_BYTES) return g;
    cur = 0;
    while (cur < HEAP_BYTES) begin
      if (cur + HDR_BYTES > HEAP_BYTES || heap_rd32(cur + 8) != HDR_MAGIC) begin
        g.status = STAT_CORRUPT;
        return g;
      end
      bsize = heap_rd32(cur);
      flag = heap_rd32(cur + 4);
      if (bsize >= req && flag == FLAG_FREE) begin
        left = bsize - req;
        if (left > HDR_BYTES + MIN_LEFTOVER) begin
          heap_wr32(cur, 32'(req));
          heap_wr32(cur + HDR_BYTES + req, left - HDR_BYTES);
          heap_wr32(cur + HDR_BYTES + req + 4, FLAG_FREE);
          heap_wr32(cur + HDR_BYTES + req + 8, HDR_MAGIC);
          bsize = 32'(req);
        end
        heap_wr32(cur + 4, '0);
        g.status = STAT_OK;
        g.payload_offset = 16'(cur + HDR_BYTES);
        g.granted_size = bsize[15:0];
        return g;
      end
      cur = cur + HDR_BYTES + bsize;
    end
    return g;
  endfunction

  // Size of the first free block in the mirror, or -1 when none is left or a header is corrupt.
  function automatic longint free_tail_size();
    longint unsigned cur;
    logic [31:0]     bsize;
    cur = 0;
    while (cur < HEAP_BYTES) begin
      if (cur + HDR_BYTES > HEAP_BYTES || heap_rd32(cur + 8) != HDR_MAGIC) return -1;
      bsize = heap_rd32(cur);
      if (heap_rd32(cur + 4) == FLAG_FREE) return longint'(bsize);
      cur = cur + HDR_BYTES + bsize;
    end
    return -1;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_req(input logic [16:0] sz, input int unsigned gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_req_size <= sz;
    do @(posedge clk); while (busy);
    pending_grants.push_back(predict_grant(sz));
  endtask

  task automatic test_edge_sizes();
    send_req(17'd0, 0);
    send_req(17'd1, 0);
    send_req(17'd65535, 2);
    send_req(17'd65536, 0);
    send_req(17'd65537, 1);
    send_req(17'd131071, 0);
    send_req(17'd100000, 5);
    send_req(17'd2047, 0);
    send_req(17'd28, 0);
    send_req(17'd29, 3);
  endtask

  task automatic test_back_to_back();
    for (int i = 0; i < 10; i++) begin
      send_req(17'($urandom_range(0, 255)), 0);
    end
  endtask

  task automatic test_random_traffic(input int unsigned beats);
    int unsigned sel;
    longint      tail;
    logic [16:0] sz;
    for (int unsigned i = 0; i < beats; i++) begin
      sel = $urandom_range(0, 99);
      tail = free_tail_size();
      if (tail >= 0 && tail <= 4096 && sel < 15) begin
        sz = 17'(tail - $urandom_range(0, (tail < 40) ? tail : 40));
      end else if (sel < 65) begin
        sz = 17'($urandom_range(0, 2047));
      end else if (sel < 75) begin
        sz = 17'($urandom_range(0, 40));
      end else if (sel < 97) begin
        sz = 17'($urandom_range(65537, 131071));
      end else begin
        sz = 17'($urandom_range(2048, 65536));
      end
      send_req(sz, pick_gap());
    end
  endtask

  task automatic test_heap_exhaustion();
    longint tail;
    tail = free_tail_size();
    if (tail >= 29) send_req(17'(tail - 29), 0);
    send_req(17'd0, 1);
    send_req(17'd0, 0);
    send_req(17'd1, 2);
    send_req(17'd65536, 0);
    send_req(17'd131071, 0);
  endtask

  always @(posedge clk) begin
    grant_t want;
    if (rst_n && out_valid) begin
      if (pending_grants.size() == 0) begin
        $error("unexpected result beat: status %0d offset %0d size %0d",
               out_status, out_payload_offset, out_granted_size);
        mismatch_count++;
      end else begin
        want = pending_grants.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_status);
          mismatch_count++;
        end
        if (out_payload_offset !== want.payload_offset) begin
          $error("payload_offset: expected %0d, actual %0d",
                 want.payload_offset, out_payload_offset);
          mismatch_count++;
        end
        if (out_granted_size !== want.granted_size) begin
          $error("granted_size: expected %0d, actual %0d",
                 want.granted_size, out_granted_size);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    foreach (heap_mirror[i]) heap_mirror[i] = 8'h00;
    heap_wr32(0, HEAP_BYTES - HDR_BYTES);
    heap_wr32(4, FLAG_FREE);
    heap_wr32(8, HDR_MAGIC);
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_edge_sizes();
    test_back_to_back();
    test_random_traffic(RANDOM_BEATS);
    test_heap_exhaustion();
    start <= 1'b0;
    while (pending_grants.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/ffha_pkg.sv
rtl/ffha_ram.sv
rtl/ffha_datapath.sv
rtl/ffha_ctrl.sv
rtl/first_fit_heap_allocator_unit.sv
rtl/ffha_checker.sv
tb/tb_top.sv
